FILE: src/ilr_pkg.sv
// Shared types, codes and sizes for the indexed insert/remove list unit.
`timescale 1ns / 1ps

package ilr_pkg;

  // Field widths
  localparam int IDX_W       = 5;
  localparam int DATA_W      = 32;
  localparam int CNT_OUT_W   = 5;
  localparam int DEF_CAPACITY = 16;

  // Command codes
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_READ   = 2'd0;
  localparam cmd_t CMD_INSERT = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;

  // Status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Input beat
  typedef struct packed {
    cmd_t                     command;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    status_t                  status;
    logic [CNT_OUT_W-1:0]     count;
  } out_beat_t;

  // Broadcast control from the command decode to every cell
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: src/ilr_cell.sv
// One list position: holds a word, loads a new one or takes one from a neighbor on insert or remove.
`timescale 1ns / 1ps

module ilr_cell #(
  parameter int POS = 0
) (
  input  logic                              clk,
  input  ilr_pkg::cell_ctrl_t               ctrl,
  input  logic signed [ilr_pkg::DATA_W-1:0] prev_data,
  input  logic signed [ilr_pkg::DATA_W-1:0] next_data,
  output logic signed [ilr_pkg::DATA_W-1:0] data,
  output logic signed [ilr_pkg::DATA_W-1:0] rd_word
);
  import ilr_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  // Pick the word for this position: shift up, load, shift down or hold
  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (POS > int'(ctrl.index)) begin
        data_nxt = prev_data;
      end else if (POS == int'(ctrl.index)) begin
        data_nxt = ctrl.value;
      end
    end else if (ctrl.rem) begin
      if (POS >= int'(ctrl.index)) begin
        data_nxt = next_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Drive the word onto the read bus when this position is addressed
  assign data    = data_r;
  assign rd_word = (POS == int'(ctrl.index)) ? data_r : '0;

endmodule

FILE: src/indexed_insert_remove_list_unit.sv
// Top level: command decode, count, chain of list cells and result register.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit words, one word per cell in a
// chain. Each command (read, insert or remove at an index) acts on the chain:
// insert shifts every cell above the index up by one neighbor and remove
// shifts them down, all in the same clock, so a command is accepted every
// cycle while the result register is free or being drained. The result
// register sets the pace: a stalled result holds off the next command. Every
// command returns one result with the word read, a status and the new count.
// Positions above 31 cannot be addressed, and the reported count wraps
// modulo 32 for a capacity above 31.
module indexed_insert_remove_list_unit #(
  parameter int CAPACITY = ilr_pkg::DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ilr_pkg::in_beat_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ilr_pkg::out_beat_t out_data
);
  import ilr_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              out_valid_r;
  out_beat_t         out_data_r;
  logic              in_fire;
  logic              do_rd;
  logic              do_ins;
  logic              do_rem;
  status_t           status;
  logic [CMPW-1:0]   idx_ext;
  logic [CMPW-1:0]   cnt_ext;
  logic [CMPW-1:0]   cnt_nxt_ext;
  cell_ctrl_t        ctrl;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_rd   [CAPACITY];
  logic signed [DATA_W-1:0] rd_bus;

  // Accept a beat whenever the result register is empty or being drained
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // Decode the command and check the index against the count
  always_comb begin
    idx_ext = CMPW'(in_data.index);
    cnt_ext = CMPW'(count_r);
    do_rd   = 1'b0;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    status  = ST_DONE;
    case (in_data.command)
      CMD_READ: begin
        if (idx_ext < cnt_ext) begin
          do_rd = 1'b1;
        end else begin
          status = ST_RANGE;
        end
      end
      CMD_INSERT: begin
        if (idx_ext > cnt_ext) begin
          status = ST_RANGE;
        end else if (cnt_ext >= CMPW'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (idx_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          do_rem = 1'b1;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  // Advance the count on a successful insert or remove
  always_comb begin
    count_nxt = count_r;
    if (in_fire && do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (in_fire && do_rem) begin
      count_nxt = count_r - CW'(1);
    end
    cnt_nxt_ext = CMPW'(count_nxt);
  end

  // Broadcast the shift controls to the chain
  always_comb begin
    ctrl.ins   = in_fire && do_ins;
    ctrl.rem   = in_fire && do_rem;
    ctrl.index = in_data.index;
    ctrl.value = in_data.value;
  end

  // Chain of cells, each fed by its lower and upper neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] prev_w;
    logic signed [DATA_W-1:0] next_w;
    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_lo
      assign prev_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_hi
      assign next_w = cell_data[g+1];
    end
    ilr_cell #(
      .POS (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .prev_data (prev_w),
      .next_data (next_w),
      .data      (cell_data[g]),
      .rd_word   (cell_rd[g])
    );
  end

  // Combine the gated cell words into the read bus
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // Hold the count and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result beat on every accepted command
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.read_value <= do_rd ? rd_bus : '0;
      out_data_r.status     <= status;
      out_data_r.count      <= cnt_nxt_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(count_r) <= CW'(CAPACITY))
    else $error("list count above capacity");

  // A successful insert grows the count by one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && do_ins) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not advance count");

  // A successful remove shrinks the count by one
  a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && do_rem) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("remove did not reduce count");

  // Input stalls only behind a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty result register");

  // A pending full status means the list is full
  a_full_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_FULL) |-> (cnt_ext == CMPW'(CAPACITY)))
    else $error("full status while list not full");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the indexed insert/remove list unit.
`timescale 1ns / 1ps

module tb_top;
  import ilr_pkg::*;

  localparam int LIST_DEPTH  = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 16;
  localparam cmd_t CMD_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  // Predicted list contents and the queue of results still owed by the block
  logic signed [DATA_W-1:0] list_words [LIST_DEPTH];
  int unsigned              list_count = 0;
  out_beat_t                owed_results [$];

  // Sender-side view of the count, advanced as each beat is issued
  int unsigned queued_count = 0;
  int          burst_left = 0;
  int          gap_max = 4;

  int stall_mode = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int err_count = 0;

  indexed_insert_remove_list_unit #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Apply one command to the predicted list and return the result it yields
  function automatic out_beat_t apply_list_cmd(in_beat_t b);
    out_beat_t   r;
    int unsigned k;
    r = '0;
    r.status = ST_DONE;
    case (b.command)
      CMD_READ: begin
        if (b.index < list_count) r.read_value = list_words[b.index];
        else r.status = ST_RANGE;
      end
      CMD_INSERT: begin
        if (b.index > list_count) begin
          r.status = ST_RANGE;
        end else if (list_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (k = list_count; k > b.index; k--) list_words[k] = list_words[k-1];
          list_words[b.index] = b.value;
          list_count++;
        end
      end
      CMD_REMOVE: begin
        if (b.index >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          for (k = b.index; k + 1 < list_count; k++) list_words[k] = list_words[k+1];
          list_words[list_count-1] = '0;
          list_count--;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = list_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_count < 100) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  // Predict on each accepted input beat, then check each accepted result beat
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) owed_results.push_back(apply_list_cmd(in_data));
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result beat with none expected");
        end else begin
          want = owed_results.pop_front();
          if (out_data.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0d want %0d",
                                      out_data.read_value, want.read_value));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data.status, want.status));
          if (out_data.count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d",
                                      out_data.count, want.count));
        end
      end
    end
  end

  // Stall the result channel in modes: none, light, heavy, periodic
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (cycle_count % 4 != 0);
    endcase
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Drive one beat, idling between bursts, and hold it until accepted
  task automatic send_beat(input cmd_t c, input logic [IDX_W-1:0] i,
                           input logic signed [DATA_W-1:0] v);
    int       gap;
    in_beat_t b;
    b.command = c;
    b.index = i;
    b.value = v;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= b;
    case (c)
      CMD_INSERT: if (i <= queued_count && queued_count < LIST_DEPTH) queued_count++;
      CMD_REMOVE: if (i < queued_count) queued_count--;
      default: ;
    endcase
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every owed result is back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_beat(CMD_READ, 0, 0);
    send_beat(CMD_REMOVE, 0, 0);
    send_beat(CMD_UNUSED, 31, '1);
  endtask

  // Insert at front, end and middle, read back, remove middle and top
  task automatic test_insert_order();
    send_beat(CMD_INSERT, 0, 32'sh7FFF_FFFF);
    send_beat(CMD_INSERT, 1, 32'sh8000_0000);
    send_beat(CMD_INSERT, 0, -1);
    send_beat(CMD_INSERT, 1, 0);
    send_beat(CMD_READ, 0, 0);
    send_beat(CMD_READ, 3, 0);
    send_beat(CMD_READ, 31, 0);
    send_beat(CMD_REMOVE, 1, 0);
    send_beat(CMD_REMOVE, 2, 0);
  endtask

  // Fill to capacity, then hit the full check and the range-before-full order
  task automatic test_full_list();
    while (queued_count < LIST_DEPTH)
      send_beat(CMD_INSERT, IDX_W'($urandom_range(0, queued_count)), random_word());
    send_beat(CMD_INSERT, IDX_W'(LIST_DEPTH), random_word());
    send_beat(CMD_INSERT, IDX_W'(LIST_DEPTH + 1), random_word());
    send_beat(CMD_READ, IDX_W'(LIST_DEPTH - 1), 0);
  endtask

  // Mostly well-formed commands in grow/shrink/mixed phases, some noise
  task automatic test_random_traffic(input int n_items);
    int          phase_left, bias, pick, n;
    int unsigned top;
    cmd_t        c;
    logic [IDX_W-1:0] idx;
    phase_left = 0;
    bias = 0;
    for (n = 0; n < n_items; n++) begin
      if (phase_left == 0) begin
        bias = $urandom_range(0, 2);
        phase_left = $urandom_range(30, 120);
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      phase_left--;
      if ($urandom_range(0, 99) < 12) begin
        c = cmd_t'($urandom_range(0, 3));
        idx = IDX_W'($urandom_range(0, 31));
      end else begin
        pick = $urandom_range(0, 99);
        case (bias)
          0: c = (pick < 60) ? CMD_INSERT : (pick < 80) ? CMD_READ : CMD_REMOVE;
          1: c = (pick < 60) ? CMD_REMOVE : (pick < 80) ? CMD_READ : CMD_INSERT;
          default: c = (pick < 35) ? CMD_INSERT : (pick < 70) ? CMD_REMOVE : CMD_READ;
        endcase
        if (queued_count == 0) c = CMD_INSERT;
        top = (c == CMD_INSERT) ? queued_count : queued_count - 1;
        pick = $urandom_range(0, 9);
        if (pick == 0) idx = '0;
        else if (pick == 1) idx = IDX_W'(top);
        else idx = IDX_W'($urandom_range(0, top));
      end
      send_beat(c, idx, random_word());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_insert_order();
    test_full_list();
    wait_for_drain();
    test_random_traffic(1400);
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
